>>> design/assert_macros.svh
// Assertion macros shared by the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define XS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define XS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define XS_ASSERT(lbl, prop, msg)
`define XS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> design/xs128_pkg.sv
// Constants, command codes and shared types of the xorshift128 generator.
`default_nettype none
package xs128_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CmdW = 3;

  localparam logic [WordW-1:0] SeedMult    = 32'h6C07_8965;
  localparam logic [WordW-1:0] DefaultSeed = 32'd42069;
  localparam logic [WordW-1:0] ZeroFixA    = 32'h0000_0001;
  localparam logic [WordW-1:0] ZeroFixB    = 32'h6C07_8967;
  localparam logic [WordW-1:0] ZeroFixC    = 32'h714A_CB41;
  localparam logic [WordW-1:0] ZeroFixD    = 32'h4807_7044;

  localparam logic [CmdW-1:0] CmdSeedDef  = 3'd0;
  localparam logic [CmdW-1:0] CmdSeedOne  = 3'd1;
  localparam logic [CmdW-1:0] CmdSeedFour = 3'd2;
  localparam logic [CmdW-1:0] CmdDraw32   = 3'd3;
  localparam logic [CmdW-1:0] CmdDraw64   = 3'd4;

  // One expanded seed word per cycle from the expansion unit
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [1:0]       idx;
    logic [WordW-1:0] word;
  } exp_status_t;

endpackage
`default_nettype wire

>>> design/xs128_expand.sv
// Single-word seed expansion: one shared 32x32 multiplier stepped over four words.
`default_nettype none
module xs128_expand
  import xs128_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WordW-1:0]  seed_i,
  output exp_status_t            status_o
);

  logic             busy_q;
  logic [1:0]       cnt_q;
  logic [WordW-1:0] prev_q;
  logic [WordW-1:0] mix;
  logic [WordW-1:0] prod;
  logic [WordW-1:0] word_d;

  always_comb begin
    mix    = prev_q ^ (prev_q >> 30);
    prod   = SeedMult * mix;
    word_d = prod + {30'd0, cnt_q} + 32'd1;
  end

  // Out of reset, expand the default seed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd0;
      prev_q <= DefaultSeed;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd0;
      prev_q <= seed_i;
    end else if (busy_q) begin
      prev_q <= word_d;
      cnt_q  <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.valid = busy_q;
    status_o.last  = (cnt_q == 2'd3);
    status_o.idx   = cnt_q;
    status_o.word  = word_d;
  end

endmodule
`default_nettype wire

>>> design/xorshift128_generator.sv
// Draws and four-word seeds give their result in the cycle after acceptance;
// one-word and default seeds first step the shared seed multiplier over all four
// words (one expanded word per cycle). Throughput: one draw per cycle unless the
// output stalls; no command is taken during an expanded seed. After reset the
// block expands the default seed 42069 and holds in_ready_o low until it is done.
`default_nettype none
`include "assert_macros.svh"
module xorshift128_generator
  import xs128_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CmdW-1:0]    cmd_i,
  input  wire logic [WordW-1:0]   seed_a_i,
  input  wire logic [WordW-1:0]   seed_b_i,
  input  wire logic [WordW-1:0]   seed_c_i,
  input  wire logic [WordW-1:0]   seed_d_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [ValueW-1:0]       value_o,
  output logic [WordW-1:0]        word_zero_o,
  output logic [WordW-1:0]        word_one_o,
  output logic [WordW-1:0]        word_two_o,
  output logic [WordW-1:0]        word_three_o
);

  localparam logic [1:0] StBoot = 2'd0;
  localparam logic [1:0] StIdle = 2'd1;
  localparam logic [1:0] StSeed = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [WordW-1:0]  words_q [4];
  logic [WordW-1:0]  words_d [4];
  logic              accept;
  logic              exp_start;
  logic [WordW-1:0]  exp_seed;
  exp_status_t       exp_st;

  // Draw datapath
  logic [WordW-1:0] t1, t2, n3, hi, lo, nw;
  logic             seed_zero;

  xs128_expand u_expand (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (exp_start),
    .seed_i   (exp_seed),
    .status_o (exp_st)
  );

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    t1 = words_q[0] ^ (words_q[0] << 11);
    nw = t1 ^ (t1 >> 8) ^ words_q[3] ^ (words_q[3] >> 19);
    n3 = t1 ^ (t1 >> 8) ^ words_q[3];
    hi = n3 ^ (words_q[3] >> 19);
    t2 = words_q[1] ^ (words_q[1] << 11);
    lo = t2 ^ (t2 >> 8) ^ hi ^ (n3 >> 19);
    seed_zero = ((seed_a_i | seed_b_i | seed_c_i | seed_d_i) == '0);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    words_d     = words_q;
    exp_start   = 1'b0;
    exp_seed    = DefaultSeed;

    // Write expanded seed words as they come
    if (exp_st.valid) begin
      words_d[exp_st.idx] = exp_st.word;
    end

    unique case (state_q)
      StBoot: begin
        if (exp_st.valid && exp_st.last) begin
          state_d = StIdle;
        end
      end
      StSeed: begin
        if (exp_st.valid && exp_st.last) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          value_d     = '0;
        end
      end
      StIdle: begin
        if (accept) begin
          value_d = '0;
          case (cmd_i)
            CmdSeedDef: begin
              exp_start = 1'b1;
              state_d   = StSeed;
            end
            CmdSeedOne: begin
              exp_start = 1'b1;
              exp_seed  = seed_a_i;
              state_d   = StSeed;
            end
            CmdSeedFour: begin
              out_valid_d = 1'b1;
              if (seed_zero) begin
                words_d[0] = ZeroFixA;
                words_d[1] = ZeroFixB;
                words_d[2] = ZeroFixC;
                words_d[3] = ZeroFixD;
              end else begin
                words_d[0] = seed_a_i;
                words_d[1] = seed_b_i;
                words_d[2] = seed_c_i;
                words_d[3] = seed_d_i;
              end
            end
            CmdDraw32: begin
              out_valid_d = 1'b1;
              value_d     = {32'd0, nw};
              words_d[0]  = words_q[1];
              words_d[1]  = words_q[2];
              words_d[2]  = words_q[3];
              words_d[3]  = nw;
            end
            CmdDraw64: begin
              out_valid_d = 1'b1;
              value_d     = {hi, lo};
              words_d[0]  = words_q[2];
              words_d[1]  = words_q[3];
              words_d[2]  = hi;
              words_d[3]  = lo;
            end
            default: begin
              // Unknown command: report the state unchanged
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StBoot;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    words_q <= words_d;
  end

  // State words change only on a new transaction or the boot expansion, so they feed the outputs directly
  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign word_zero_o  = words_q[0];
  assign word_one_o   = words_q[1];
  assign word_two_o   = words_q[2];
  assign word_three_o = words_q[3];

  `XS_ASSERT(a_exp_not_idle, exp_st.valid |-> (state_q != StIdle), "expansion runs while idle")
  `XS_ASSERT(a_words_hold, (out_valid_o && !out_ready_i) |=> ($stable(word_zero_o) && $stable(word_one_o) && $stable(word_two_o) && $stable(word_three_o)), "state words moved under a waiting result")
  `XS_ASSERT(a_seed_done, (state_q == StSeed && exp_st.valid && exp_st.last) |=> (out_valid_o && state_q == StIdle), "seed result missing")
  `XS_ASSERT_NEVER(a_boot_quiet, (state_q == StBoot) && out_valid_o, "result during boot expansion")

endmodule
`default_nettype wire

>>> test/xorshift128_generator_test.sv
// Self-checking testbench for the xorshift128 generator: seeds, draws, unused codes and handshake stalls.
`timescale 1ns / 100ps
module xorshift128_generator_test
  import xs128_pkg::*;
();

  localparam int unsigned CyclesLimit  = 500000;
  localparam int unsigned ItemsPerPass = 450;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned MaxReports   = 40;
  localparam logic [CmdW-1:0] CmdUnusedLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUnusedHi = 3'd7;

  typedef logic [3:0][WordW-1:0] gen_words_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    gen_words_t        words;
  } gen_result_t;

  class GenScoreboard;
    gen_words_t  gen_words;
    gen_result_t expected_q[$];
    int unsigned mismatches;
    int unsigned reports;

    function new();
      mismatches = 0;
      reports = 0;
      load_expanded(DefaultSeed);
    endfunction

    function logic [WordW-1:0] expand_word(logic [WordW-1:0] prev, logic [WordW-1:0] add);
      return SeedMult * (prev ^ (prev >> 30)) + add;
    endfunction

    function void load_expanded(logic [WordW-1:0] seed);
      gen_words[0] = expand_word(seed, 32'd1);
      gen_words[1] = expand_word(gen_words[0], 32'd2);
      gen_words[2] = expand_word(gen_words[1], 32'd3);
      gen_words[3] = expand_word(gen_words[2], 32'd4);
    endfunction

    function logic [WordW-1:0] step32();
      logic [WordW-1:0] t;
      logic [WordW-1:0] nw;
      t = gen_words[0] ^ (gen_words[0] << 11);
      nw = t ^ (t >> 8) ^ gen_words[3] ^ (gen_words[3] >> 19);
      gen_words = {nw, gen_words[3], gen_words[2], gen_words[1]};
      return nw;
    endfunction

    function logic [ValueW-1:0] step64();
      logic [WordW-1:0] t1;
      logic [WordW-1:0] t2;
      logic [WordW-1:0] n3;
      logic [WordW-1:0] hi;
      logic [WordW-1:0] lo;
      t1 = gen_words[0] ^ (gen_words[0] << 11);
      n3 = t1 ^ (t1 >> 8) ^ gen_words[3];
      hi = n3 ^ (gen_words[3] >> 19);
      t2 = gen_words[1] ^ (gen_words[1] << 11);
      lo = t2 ^ (t2 >> 8) ^ hi ^ (n3 >> 19);
      gen_words = {lo, hi, gen_words[3], gen_words[2]};
      return {hi, lo};
    endfunction

    // Advance the predicted state for one accepted command and queue its result
    function void note_command(logic [CmdW-1:0] cmd, logic [WordW-1:0] sa,
                               logic [WordW-1:0] sb, logic [WordW-1:0] sc,
                               logic [WordW-1:0] sd);
      gen_result_t res;
      res.value = '0;
      case (cmd)
        CmdSeedDef: load_expanded(DefaultSeed);
        CmdSeedOne: load_expanded(sa);
        CmdSeedFour: begin
          if ((sa | sb | sc | sd) == '0) begin
            gen_words = {ZeroFixD, ZeroFixC, ZeroFixB, ZeroFixA};
          end else begin
            gen_words = {sd, sc, sb, sa};
          end
        end
        CmdDraw32: res.value = {32'd0, step32()};
        CmdDraw64: res.value = step64();
        default: ;
      endcase
      res.words = gen_words;
      expected_q.push_back(res);
    endfunction

    function void report_field(string name, logic [ValueW-1:0] exp_v, logic [ValueW-1:0] act_v);
      mismatches++;
      if (reports < MaxReports) begin
        reports++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [ValueW-1:0] value, gen_words_t words);
      gen_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual value %h", $time, value);
        return;
      end
      exp_r = expected_q.pop_front();
      if (value !== exp_r.value) report_field("value", exp_r.value, value);
      if (words[0] !== exp_r.words[0]) begin
        report_field("word_zero", {32'd0, exp_r.words[0]}, {32'd0, words[0]});
      end
      if (words[1] !== exp_r.words[1]) begin
        report_field("word_one", {32'd0, exp_r.words[1]}, {32'd0, words[1]});
      end
      if (words[2] !== exp_r.words[2]) begin
        report_field("word_two", {32'd0, exp_r.words[2]}, {32'd0, words[2]});
      end
      if (words[3] !== exp_r.words[3]) begin
        report_field("word_three", {32'd0, exp_r.words[3]}, {32'd0, words[3]});
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CmdW-1:0]   cmd_i = '0;
  logic [WordW-1:0]  seed_a_i = '0;
  logic [WordW-1:0]  seed_b_i = '0;
  logic [WordW-1:0]  seed_c_i = '0;
  logic [WordW-1:0]  seed_d_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ValueW-1:0] value_o;
  logic [WordW-1:0]  word_zero_o;
  logic [WordW-1:0]  word_one_o;
  logic [WordW-1:0]  word_two_o;
  logic [WordW-1:0]  word_three_o;

  GenScoreboard gen_sb = new();

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 88;
  int unsigned hold_len = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  xorshift128_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .seed_a_i     (seed_a_i),
    .seed_b_i     (seed_b_i),
    .seed_c_i     (seed_c_i),
    .seed_d_i     (seed_d_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .word_zero_o  (word_zero_o),
    .word_one_o   (word_one_o),
    .word_two_o   (word_two_o),
    .word_three_o (word_three_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CyclesLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold when requested
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      gen_sb.check_result(value_o, {word_three_o, word_two_o, word_one_o, word_zero_o});
    end
  end

  // Offer one transaction and hold it until accepted; returns at the next falling edge
  task automatic send_command(logic [CmdW-1:0] cmd, logic [WordW-1:0] sa,
                              logic [WordW-1:0] sb, logic [WordW-1:0] sc,
                              logic [WordW-1:0] sd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    seed_a_i = sa;
    seed_b_i = sb;
    seed_c_i = sc;
    seed_d_i = sd;
    do @(posedge clk_i); while (!in_ready_o);
    gen_sb.note_command(cmd, sa, sb, sc, sd);
    @(negedge clk_i);
  endtask

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random();
    int unsigned pick;
    logic [3:0][WordW-1:0] w;
    pick = $urandom_range(99);
    w = {$urandom(), $urandom(), $urandom(), $urandom()};
    if (pick < 35) begin
      send_command(CmdDraw32, w[0], w[1], w[2], w[3]);
    end else if (pick < 70) begin
      send_command(CmdDraw64, w[0], w[1], w[2], w[3]);
    end else if (pick < 80) begin
      send_command(CmdSeedOne, pick_word(), w[1], w[2], w[3]);
    end else if (pick < 90) begin
      case ($urandom_range(5))
        0: w = '0;
        1: begin
          w = '0;
          w[$urandom_range(3)] = pick_word() | 32'd1;
        end
        default: w = {pick_word(), pick_word(), pick_word(), pick_word()};
      endcase
      send_command(CmdSeedFour, w[0], w[1], w[2], w[3]);
    end else if (pick < 94) begin
      send_command(CmdSeedDef, w[0], w[1], w[2], w[3]);
    end else begin
      send_command(CmdUnusedLo + CmdW'($urandom_range(CmdUnusedHi - CmdUnusedLo)),
                   w[0], w[1], w[2], w[3]);
    end
  endtask

  task automatic wait_drained();
    while (gen_sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: state after reset, field extremes, the zero four-word seed, unused codes
    send_command(CmdDraw32, '0, '0, '0, '0);
    send_command(CmdDraw64, '1, '1, '1, '1);
    send_command(CmdSeedDef, '1, 32'h5555_5555, 32'hAAAA_AAAA, '1);
    send_command(CmdDraw32, '1, '1, '1, '1);
    send_command(CmdSeedOne, '0, '1, '1, '1);
    send_command(CmdDraw64, '0, '0, '0, '0);
    send_command(CmdSeedOne, '1, '0, '0, '0);
    send_command(CmdDraw32, '0, '0, '0, '0);
    send_command(CmdSeedOne, DefaultSeed, '0, '0, '0);
    send_command(CmdSeedFour, '0, '0, '0, '0);
    send_command(CmdDraw32, '0, '0, '0, '0);
    send_command(CmdDraw64, '0, '0, '0, '0);
    send_command(CmdSeedFour, '1, '1, '1, '1);
    send_command(CmdDraw64, '0, '0, '0, '0);
    send_command(CmdDraw32, '0, '0, '0, '0);
    send_command(CmdSeedFour, '0, '0, '0, 32'h8000_0000);
    send_command(CmdDraw32, '0, '0, '0, '0);
    send_command(CmdSeedFour, 32'd1, '0, '0, '0);
    send_command(CmdDraw64, '0, '0, '0, '0);
    send_command(CmdUnusedLo, '1, '1, '1, '1);
    send_command(CmdUnusedLo + 3'd1, $urandom(), $urandom(), $urandom(), $urandom());
    send_command(CmdUnusedHi, '0, '0, '0, '0);
    send_command(CmdDraw32, '0, '0, '0, '0);

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin send_idle_pct = 29; recv_idle_pct = 88; end
        1: begin send_idle_pct = 88; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < ItemsPerPass; n++) begin
        if (pass == 1 && n == 150) begin
          // Stop the receiver and keep feeding draws so the input stalls
          send_idle_pct = 0;
          hold_len = 120;
          hold_req = 1'b1;
          for (int k = 0; k < 30; k++) begin
            send_command(CmdDraw64, $urandom(), $urandom(), $urandom(), $urandom());
          end
          send_idle_pct = 88;
        end
        if (pass == 2 && n == 200) begin
          in_valid_i = 1'b0;
          wait_drained();
        end
        send_random();
      end
    end

    in_valid_i = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (gen_sb.mismatches == 0 && gen_sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/xs128_pkg.sv
design/xs128_expand.sv
design/xorshift128_generator.sv
test/xorshift128_generator_test.sv
